// ===== rtl/rce_pkg.sv =====
// Shared definitions for the context-modelled rANS encoder.
// Holds field widths, operation codes and default parameter values.
// No dependencies.
package rce_pkg;

   localparam int CONTEXTS_DEF   = 64;
   localparam int SCALE_BITS_DEF = 12;

   localparam int OP_W      = 2;
   localparam int CTX_W     = 6;
   localparam int SYM_W     = 8;
   localparam int FREQ_W    = 13;
   localparam int START_W   = 12;
   localparam int STATE_W   = 24;
   localparam int BYTE_W    = 8;

   // Request payload: context, symbol, frequency, start, padded to whole bytes.
   localparam int REQ_FIELDS_W = CTX_W + SYM_W + FREQ_W + START_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;

   localparam logic [STATE_W-1:0] RANS_LOW = STATE_W'(32'h0001_0000);

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_WRITE  = 2'd0;
   localparam op_type OP_ENCODE = 2'd1;
   localparam op_type OP_FLUSH  = 2'd2;

endpackage

// ===== rtl/rans_context_encoder.sv =====
// Context-modelled rANS encoder with byte-wise renormalization.
// Holds the frequency table, the coder state and a bit-serial divider.
// Depends on rce_pkg.
//
//   Channel | Direction | tdata (low bit first)                    | side band
//   --------+-----------+------------------------------------------+-----------------
//   req     | in        | context, symbol, freq, start (+ pad)     | tuser = operation
//   rsp     | out       | out_byte                                 | tlast = last
//
// A table write leaves the block idle. An encode reads the table, emits the renormalization
// bytes (none or more), runs the restoring divider over all 24 state bits (one quotient bit
// per cycle) and ends in an update state; an entry with zero frequency ends it after the read.
// A flush emits four bytes, one per state byte, and then reloads the coder state.
// Reset is synchronous; it loads the coder state with 65536 and leaves the table undefined.
// A stalled result side holds the block in place; one finished byte waits in the output
// register while the block continues.
module rans_context_encoder #(
   parameter int CONTEXTS   = rce_pkg::CONTEXTS_DEF,
   parameter int SCALE_BITS = rce_pkg::SCALE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // context [5:0], symbol [13:6], freq [26:14], start [38:27], zero pad above
   input  logic [rce_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation [1:0]
   input  logic [rce_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_byte [7:0]
   output logic [rce_pkg::BYTE_W-1:0]     rsp_tdata,
   output logic                           rsp_tlast
);
   import rce_pkg::*;

   localparam int DEPTH      = CONTEXTS * 256;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int RENORM_SH  = 24 - SCALE_BITS;
   localparam int LIM_W      = FREQ_W + RENORM_SH;
   localparam int CMP_W      = (LIM_W > STATE_W) ? LIM_W : STATE_W;
   localparam int ENTRY_W    = FREQ_W + START_W;
   localparam logic [8:0] CTX_LIMIT = 9'(CONTEXTS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RENORM = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_FLUSH  = 3'd4;

   localparam logic [4:0] DIV_LAST  = 5'(STATE_W - 1);

   // Request fields.
   logic [CTX_W-1:0]   req_ctx;
   logic [SYM_W-1:0]   req_sym;
   logic [FREQ_W-1:0]  req_freq;
   logic [START_W-1:0] req_start;
   op_type             req_op;
   logic               ctx_ok;
   logic [ADDR_W-1:0]  req_addr;

   assign req_ctx   = req_tdata[CTX_W-1:0];
   assign req_sym   = req_tdata[CTX_W+SYM_W-1:CTX_W];
   assign req_freq  = req_tdata[CTX_W+SYM_W+FREQ_W-1:CTX_W+SYM_W];
   assign req_start = req_tdata[REQ_FIELDS_W-1:CTX_W+SYM_W+FREQ_W];
   assign req_op    = req_tuser;
   assign ctx_ok    = ({3'b000, req_ctx} < CTX_LIMIT);
   assign req_addr  = ADDR_W'({8'(req_ctx), req_sym});

   // Control and datapath registers.
   logic [2:0]          state_ff, state_in;
   logic [4:0]          count_ff, count_in;
   logic [STATE_W-1:0]  coder_ff, coder_in;
   logic [FREQ_W-1:0]   rem_ff, rem_in;
   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;

   // Frequency and start table.
   logic [ENTRY_W-1:0]  table_mem [0:DEPTH-1];
   logic [ENTRY_W-1:0]  entry_ff;
   logic [FREQ_W-1:0]   ent_freq;
   logic [START_W-1:0]  ent_start;

   logic                accept;
   logic                wr_en;
   logic                rd_en;
   logic                out_free;
   logic                out_load;
   logic [CMP_W-1:0]    limit;
   logic                need_byte;
   logic                need_next;
   logic [FREQ_W:0]     trial;
   logic                trial_ge;

   assign accept    = req_tvalid && req_tready;
   assign wr_en     = accept && (req_op == OP_WRITE) && ctx_ok;
   assign rd_en     = accept && (req_op == OP_ENCODE) && ctx_ok;
   assign ent_freq  = entry_ff[ENTRY_W-1:START_W];
   assign ent_start = entry_ff[START_W-1:0];
   assign out_free  = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[req_addr] <= {req_freq, req_start};
      end
      if (rd_en) begin
         entry_ff <= table_mem[req_addr];
      end
   end

   // Renormalization test: state >= freq << (24 - SCALE_BITS), now and after one more byte.
   assign limit     = CMP_W'(ent_freq) << RENORM_SH;
   assign need_byte = (CMP_W'(coder_ff) >= limit) && (count_ff < 5'd4);
   assign need_next = (CMP_W'(coder_ff >> BYTE_W) >= limit) && (count_ff < 5'd3);

   // One restoring division step: shift in the next dividend bit and try the subtraction.
   assign trial    = {rem_ff, coder_ff[STATE_W-1]};
   assign trial_ge = (trial >= (FREQ_W+1)'(ent_freq));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      coder_in     = coder_ff;
      rem_in       = rem_ff;
      out_load     = 1'b0;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = 5'd0;
               if (req_op == OP_ENCODE && ctx_ok) begin
                  state_in = ST_RENORM;
               end else if (req_op == OP_FLUSH) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_RENORM: begin
            if (ent_freq == '0) begin
               state_in = ST_IDLE;
            end else if (!need_byte) begin
               state_in = ST_DIV;
               rem_in   = '0;
               count_in = 5'd0;
            end else if (out_free) begin
               out_load    = 1'b1;
               out_byte_in = coder_ff[BYTE_W-1:0];
               out_last_in = !need_next;
               coder_in    = coder_ff >> BYTE_W;
               count_in    = count_ff + 5'd1;
               if (!need_next) begin
                  state_in = ST_DIV;
                  rem_in   = '0;
                  count_in = 5'd0;
               end
            end
         end
         ST_DIV: begin
            coder_in = {coder_ff[STATE_W-2:0], trial_ge};
            if (trial_ge) begin
               rem_in = FREQ_W'(trial - (FREQ_W+1)'(ent_freq));
            end else begin
               rem_in = FREQ_W'(trial);
            end
            count_in = count_ff + 5'd1;
            if (count_ff == DIV_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            coder_in = (coder_ff << SCALE_BITS) + STATE_W'(rem_ff) + STATE_W'(ent_start);
            state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_byte_in = coder_ff[BYTE_W-1:0];
               out_last_in = (count_ff == 5'd3);
               coder_in    = coder_ff >> BYTE_W;
               count_in    = count_ff + 5'd1;
               if (count_ff == 5'd3) begin
                  coder_in = RANS_LOW;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 5'd0;
         coder_ff     <= RANS_LOW;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         coder_ff     <= coder_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   // No transaction is taken while reset is held.
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

   // The divider never runs past the last quotient bit.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (count_ff <= DIV_LAST))
      else $error("divider step count out of range");

   // The partial remainder always stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < ent_freq))
      else $error("partial remainder not below frequency");

   // A byte is only placed in the output register when the previous one has gone.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_tready))
      else $error("output register overwritten");

   // The last flush byte reloads the start value.
   a_flush_reload: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_load && count_ff == 5'd3) |=> (coder_ff == RANS_LOW))
      else $error("coder state not reloaded after flush");

endmodule
